>>> rtl/hfjs_pkg.sv
// ----------------------------------------------------------------------------
// hfjs_pkg
// shared types, codes and constants of the fcfs / hrn job scheduler
// ----------------------------------------------------------------------------
package hfjs_pkg;

   localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
   localparam int unsigned RATIO_W             = 16;
   localparam logic [RATIO_W-1:0] RATIO_MAX    = '1;

   localparam logic OP_SUBMIT   = 1'b0;
   localparam logic OP_SCHEDULE = 1'b1;

   localparam logic MODE_FCFS = 1'b0;
   localparam logic MODE_HRN  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        op;
      logic [7:0]  job_id;
      logic [15:0] svc_len;
      logic [15:0] initial_priority;
      logic [31:0] now;
      logic        has_finished;
   } req_type;

   typedef struct packed {
      logic [7:0]  granted_id;
      logic        grant_valid;
      logic [31:0] end_ts;
      logic [1:0]  status;
      logic [4:0]  ready_count;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         job_id;
      logic [15:0]        svc_len;
      logic [31:0]        arrival_ts;
      logic [RATIO_W-1:0] priority_val;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_SHIFT,
      ST_INS,
      ST_R_DIV,
      ST_R_WAIT,
      ST_S_START,
      ST_S_KEY,
      ST_S_CMP,
      ST_S_PUT,
      ST_G_START,
      ST_G_HEAD,
      ST_G_SHIFT,
      ST_RESP
   } state_type;

endpackage

>>> rtl/hfjs_entry_ram.sv
// ----------------------------------------------------------------------------
// hfjs_entry_ram
// queue entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module hfjs_entry_ram
   import hfjs_pkg::*;
#(
   parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hfjs_ratio_div.sv
// ----------------------------------------------------------------------------
// hfjs_ratio_div
// response ratio (wait + need) / need, one quotient bit per cycle, saturating
// ----------------------------------------------------------------------------
module hfjs_ratio_div
   import hfjs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        now,
   input  logic [31:0]        arrival_ts,
   input  logic [15:0]        svc_len,
   output logic               busy,
   output logic               done,
   output logic [RATIO_W-1:0] ratio
);

   localparam int unsigned CW = $clog2(RATIO_W + 1);

   logic [32:0]        div_ff, div_in;
   logic [15:0]        den_ff, den_in;
   logic [15:0]        rem_ff, rem_in;
   logic [RATIO_W-1:0] quo_ff, quo_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               setup_ff, setup_in;
   logic               done_ff, done_in;
   logic [16:0]        trial;

   always_comb begin
      div_in   = div_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      setup_in = 1'b0;
      done_in  = 1'b0;
      trial    = {rem_ff, quo_ff[RATIO_W-1]};
      if (start) begin
         div_in   = {1'b0, now - arrival_ts} + {17'd0, svc_len};
         den_in   = svc_len;
         busy_in  = 1'b1;
         setup_in = 1'b1;
      end else if (setup_ff) begin
         if ((den_ff == 16'd0) || (div_ff[32:16] >= {1'b0, den_ff})) begin
            quo_in  = RATIO_MAX;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in = div_ff[31:16];
            quo_in = div_ff[15:0];
            cnt_in = CW'(RATIO_W);
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 16'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[RATIO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[RATIO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         setup_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         setup_ff <= setup_in;
         done_ff  <= done_in;
      end
      div_ff <= div_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign busy  = busy_ff;
   assign done  = done_ff;
   assign ratio = quo_ff;

endmodule

>>> rtl/hrn_fcfs_job_scheduler.sv
// ----------------------------------------------------------------------------
// hrn_fcfs_job_scheduler
// ready queue with fcfs and hrn policies, entries held in one synchronous ram
// ----------------------------------------------------------------------------
// fcfs submit, full, empty go straight to ST_RESP; hrn submit scans (ST_FIND),
// shifts (ST_SHIFT), writes (ST_INS); schedule reads the head (ST_G_HEAD), shifts
// (ST_G_SHIFT); a stalled response holds ST_RESP; hrn schedule with a finished
// job first reruns the serial ratio divider per entry, then an insertion sort
// one item in flight at a time; the ram port and the serial divider set the rate
// reset: synchronous, queue empty and fcfs mode; entries are not cleared
module hrn_fcfs_job_scheduler
   import hfjs_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);
   localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

   state_type          state_ff, state_in;
   logic               mode_ff, mode_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [LW-1:0]      i_ff, i_in;
   logic [LW-1:0]      j_ff, j_in;
   logic [LW-1:0]      pos_ff, pos_in;
   req_type            req_ff, req_in;
   entry_type          key_ff, key_in;
   rsp_type            pend_ff, pend_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               wr_en;
   logic [LW-1:0]      wr_idx;
   logic [LW-1:0]      rd_idx;
   entry_type          wr_data;
   entry_type          rd_data;
   entry_type          new_entry;
   logic               div_start;
   logic               div_busy;
   logic               div_done;
   logic [RATIO_W-1:0] div_ratio;
   logic               accept;
   logic               rsp_free;
   logic [LW-1:0]      i_nx;
   logic [LW-1:0]      j_nx;

   hfjs_entry_ram #(
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   hfjs_ratio_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .now        (req_ff.now),
      .arrival_ts (rd_data.arrival_ts),
      .svc_len    (rd_data.svc_len),
      .busy       (div_busy),
      .done       (div_done),
      .ratio      (div_ratio)
   );

   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign i_nx      = i_ff + LW'(1);
   assign j_nx      = j_ff + LW'(1);
   assign new_entry = '{job_id:       req_ff.job_id,
                        svc_len:      req_ff.svc_len,
                        arrival_ts:   req_ff.now,
                        priority_val: req_ff.initial_priority};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_SUBMIT) begin
                  if ((len_ff == LW'(QUEUE_DEPTH)) || (mode_ff == MODE_FCFS)
                      || (len_ff == '0)) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_FIND;
                  end
               end else if (len_ff == '0) begin
                  state_in = ST_RESP;
               end else if ((mode_ff == MODE_HRN) && req_data.has_finished
                            && (len_ff != LW'(1))) begin
                  state_in = ST_R_DIV;
               end else begin
                  state_in = ST_G_HEAD;
               end
            end
         end
         ST_FIND: begin
            if (rd_data.priority_val < req_ff.initial_priority) begin
               state_in = ST_SHIFT;
            end else if (i_nx == len_ff) begin
               state_in = ST_INS;
            end
         end
         ST_SHIFT: begin
            if (j_ff - LW'(1) == pos_ff) begin
               state_in = ST_INS;
            end
         end
         ST_INS:    state_in = ST_RESP;
         ST_R_DIV:  state_in = ST_R_WAIT;
         ST_R_WAIT: begin
            if (div_done) begin
               state_in = (i_nx == len_ff) ? ST_S_START : ST_R_DIV;
            end
         end
         ST_S_START: state_in = ST_S_KEY;
         ST_S_KEY:   state_in = ST_S_CMP;
         ST_S_CMP: begin
            if (!(rd_data.priority_val < key_ff.priority_val) || (j_ff == '0)) begin
               state_in = ST_S_PUT;
            end
         end
         ST_S_PUT: state_in = (i_nx == len_ff) ? ST_G_START : ST_S_KEY;
         ST_G_START: state_in = ST_G_HEAD;
         ST_G_HEAD:  state_in = (len_ff == LW'(1)) ? ST_RESP : ST_G_SHIFT;
         ST_G_SHIFT: begin
            if (j_nx == len_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      req_in       = req_ff;
      key_in       = key_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_idx       = '0;
      wr_data      = new_entry;
      div_start    = 1'b0;
      req_ready    = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               pend_in = '0;
               i_in    = '0;
               if (req_data.op == OP_SUBMIT) begin
                  if (len_ff == LW'(QUEUE_DEPTH)) begin
                     pend_in.status = STATUS_FULL;
                  end else if ((mode_ff == MODE_FCFS) || (len_ff == '0)) begin
                     wr_en   = 1'b1;
                     wr_idx  = len_ff;
                     wr_data = '{job_id:       req_data.job_id,
                                 svc_len:      req_data.svc_len,
                                 arrival_ts:   req_data.now,
                                 priority_val: req_data.initial_priority};
                     len_in  = len_ff + LW'(1);
                  end
               end else if (len_ff == '0) begin
                  pend_in.status = STATUS_EMPTY;
               end
            end
         end
         ST_FIND: begin
            if (rd_data.priority_val < req_ff.initial_priority) begin
               pos_in = i_ff;
               j_in   = len_ff;
            end else if (i_nx == len_ff) begin
               pos_in = len_ff;
            end else begin
               i_in = i_nx;
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_idx  = j_ff;
            wr_data = rd_data;
            j_in    = j_ff - LW'(1);
         end
         ST_INS: begin
            wr_en  = 1'b1;
            wr_idx = pos_ff;
            len_in = len_ff + LW'(1);
         end
         ST_R_DIV: begin
            div_start = 1'b1;
            key_in    = rd_data;
         end
         ST_R_WAIT: begin
            if (div_done) begin
               wr_en                = 1'b1;
               wr_idx               = i_ff;
               wr_data              = key_ff;
               wr_data.priority_val = div_ratio;
               i_in                 = i_nx;
            end
         end
         ST_S_START: i_in = LW'(1);
         ST_S_KEY: begin
            key_in = rd_data;
            j_in   = i_ff - LW'(1);
         end
         ST_S_CMP: begin
            if (rd_data.priority_val < key_ff.priority_val) begin
               wr_en   = 1'b1;
               wr_idx  = j_nx;
               wr_data = rd_data;
               if (j_ff == '0) begin
                  pos_in = '0;
               end else begin
                  j_in = j_ff - LW'(1);
               end
            end else begin
               pos_in = j_nx;
            end
         end
         ST_S_PUT: begin
            wr_en   = 1'b1;
            wr_idx  = pos_ff;
            wr_data = key_ff;
            i_in    = i_nx;
         end
         ST_G_START: begin
         end
         ST_G_HEAD: begin
            pend_in.granted_id  = rd_data.job_id;
            pend_in.grant_valid = 1'b1;
            pend_in.end_ts      = req_ff.now + {16'd0, rd_data.svc_len};
            j_in                = LW'(1);
            if (len_ff == LW'(1)) begin
               len_in = '0;
            end
         end
         ST_G_SHIFT: begin
            wr_en   = 1'b1;
            wr_idx  = j_ff - LW'(1);
            wr_data = rd_data;
            j_in    = j_nx;
            if (j_nx == len_ff) begin
               len_in = len_ff - LW'(1);
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_in             = pend_ff;
               rsp_in.ready_count = 5'(len_ff);
               rsp_valid_in       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // read address follows the entry each state consumes on its next cycle
   always_comb begin
      unique case (state_in)
         ST_FIND, ST_R_DIV, ST_S_KEY: rd_idx = i_in;
         ST_SHIFT:                    rd_idx = j_in - LW'(1);
         ST_S_CMP, ST_G_SHIFT:        rd_idx = j_in;
         default:                     rd_idx = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_FCFS;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      pos_ff  <= pos_in;
      req_ff  <= req_in;
      key_ff  <= key_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(QUEUE_DEPTH))
      else $error("queue length above depth");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("ratio divider restarted while busy");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.grant_valid) |-> (rsp_data.status == STATUS_OK))
      else $error("grant with error status");

   a_grant_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_G_HEAD) && (len_ff == LW'(1)) |=> (len_ff == '0))
      else $error("single grant left queue non-empty");
`endif

endmodule

>>> tb/hrn_fcfs_job_scheduler_tb.sv
// ----------------------------------------------------------------------------
// hrn_fcfs_job_scheduler_tb
// self-checking bench: a directed table then random submit / schedule traffic
// in both policies, every response checked against a queue model in the bench
// ----------------------------------------------------------------------------
module hrn_fcfs_job_scheduler_tb;
   import hfjs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 8000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic    csr_wr_data = 1'b0;

   hrn_fcfs_job_scheduler #(.QUEUE_DEPTH(DEPTH)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench copy of the ready queue
   logic       mode_q;
   entry_type  jobs_q[$];
   rsp_type    grants_due[$];
   int         errors = 0;
   int         idle_cycles = 0;
   int         n_sent = 0, n_grants = 0, n_hrn = 0;
   bit         idle_on = 1;

   function automatic logic [15:0] ratio_of(logic [31:0] t_now, entry_type e);
      logic [31:0] d;
      logic [63:0] w, r;
      if (e.svc_len == 16'd0) return RATIO_MAX;
      d = t_now - e.arrival_ts;
      w = 64'(d);
      r = (w + 64'(e.svc_len)) / 64'(e.svc_len);
      return (r > 64'hFFFF) ? RATIO_MAX : r[15:0];
   endfunction

   function automatic int slot_for(entry_type q[$], logic [15:0] p);
      for (int k = 0; k < q.size(); k++)
         if (q[k].priority_val < p) return k;
      return q.size();
   endfunction

   function automatic rsp_type schedule_job(req_type r);
      rsp_type   o;
      entry_type e, srt[$];
      o = '0;
      if (r.op == OP_SUBMIT) begin
         e = '{r.job_id, r.svc_len, r.now, r.initial_priority};
         if (jobs_q.size() >= DEPTH) o.status = STATUS_FULL;
         else if (mode_q == MODE_FCFS) jobs_q.push_back(e);
         else jobs_q.insert(slot_for(jobs_q, e.priority_val), e);
      end else begin
         if (mode_q == MODE_HRN && r.has_finished) begin
            foreach (jobs_q[k]) begin
               e = jobs_q[k];
               e.priority_val = ratio_of(r.now, e);
               srt.insert(slot_for(srt, e.priority_val), e);
            end
            jobs_q = srt;
         end
         if (jobs_q.size() == 0) o.status = STATUS_EMPTY;
         else begin
            e = jobs_q.pop_front();
            o.granted_id  = e.job_id;
            o.grant_valid = 1'b1;
            o.end_ts      = r.now + 32'(e.svc_len);
         end
      end
      o.ready_count = 5'(jobs_q.size());
      return o;
   endfunction

   // response side
   always @(posedge clock) begin
      rsp_type x;
      if (!reset) begin
         rsp_ready <= (!idle_on || $urandom_range(99) >= 34);
         if (rsp_valid && rsp_ready) begin
            if (grants_due.size() == 0) begin
               $error("unexpected transfer %p", rsp_data);
               errors++;
            end else begin
               x = grants_due.pop_front();
               if (rsp_data.granted_id !== x.granted_id) begin
                  $error("granted_id exp %0d got %0d", x.granted_id, rsp_data.granted_id);
                  errors++;
               end
               if (rsp_data.grant_valid !== x.grant_valid) begin
                  $error("grant_valid exp %0d got %0d", x.grant_valid, rsp_data.grant_valid);
                  errors++;
               end
               if (rsp_data.end_ts !== x.end_ts) begin
                  $error("end_ts exp %0d got %0d", x.end_ts, rsp_data.end_ts);
                  errors++;
               end
               if (rsp_data.status !== x.status) begin
                  $error("status exp %0d got %0d", x.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.ready_count !== x.ready_count) begin
                  $error("ready_count exp %0d got %0d", x.ready_count,
                         rsp_data.ready_count);
                  errors++;
               end
               if (x.grant_valid) n_grants++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("hrn_fcfs_job_scheduler_tb: FAIL");
         $finish;
      end
   end

   task automatic send_item(req_type r, bit has_exp = 0, rsp_type exp = '0);
      rsp_type p;
      while (idle_on && $urandom_range(99) < 34) @(posedge clock);
      p = schedule_job(r);
      if (has_exp && p !== exp) begin
         $error("table row exp %p model %p", exp, p);
         errors++;
      end
      grants_due.push_back(p);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      @(posedge clock);
      n_sent++;
      if (mode_q == MODE_HRN) n_hrn++;
   endtask

   task automatic set_mode(logic m);
      while (grants_due.size() != 0) @(posedge clock);
      repeat (DEPTH * DEPTH * 2 + 40 * DEPTH) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_q = m;
   endtask

   function automatic req_type rand_item(int phase);
      req_type r;
      r.op               = ($urandom_range(99) < (phase ? 45 : 55)) ? OP_SUBMIT : OP_SCHEDULE;
      r.job_id           = 8'($urandom);
      r.svc_len          = ($urandom_range(9) == 0) ? 16'($urandom_range(1)) : 16'($urandom);
      r.initial_priority = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
      r.now              = $urandom;
      r.has_finished     = 1'($urandom_range(1));
      return r;
   endfunction

   typedef struct {
      req_type r;
      bit      chk;
      rsp_type x;
   } row_type;

   initial begin
      row_type rows[$];
      rsp_type z;
      mode_q = MODE_FCFS;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty, extremes, full queue
      z = '0; z.status = STATUS_EMPTY;
      rows.push_back('{'{OP_SCHEDULE, 8'd0, 16'd0, 16'd0, 32'd0, 1'b1}, 1, z});
      z = '0; z.ready_count = 5'd1;
      rows.push_back('{'{OP_SUBMIT, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1}, 1, z});
      z = '0; z.granted_id = 8'hFF; z.grant_valid = 1'b1; z.end_ts = 32'h0000_FFFE;
      rows.push_back('{'{OP_SCHEDULE, 8'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 1'b0}, 1, z});
      for (int k = 0; k < DEPTH; k++)
         rows.push_back('{'{OP_SUBMIT, 8'(k), 16'(k), 16'(k), 32'(k), 1'b0}, 0, z});
      z = '0; z.status = STATUS_FULL; z.ready_count = 5'(DEPTH);
      rows.push_back('{'{OP_SUBMIT, 8'h00, 16'h0, 16'h0, 32'h0, 1'b0}, 1, z});
      foreach (rows[k]) send_item(rows[k].r, rows[k].chk, rows[k].x);
      rows.delete();

      // hrn with equal priorities, zero need and time going back
      set_mode(MODE_HRN);
      send_item('{OP_SCHEDULE, 8'd0, 16'd0, 16'd0, 32'd100, 1'b1});
      send_item('{OP_SUBMIT, 8'd1, 16'd0, 16'd5, 32'd200, 1'b0});
      send_item('{OP_SUBMIT, 8'd2, 16'd1, 16'd5, 32'd300, 1'b0});
      send_item('{OP_SCHEDULE, 8'd0, 16'd0, 16'd0, 32'd10, 1'b1});
      while (grants_due.size() != 0) @(posedge clock);

      // random traffic, policy switched with jobs waiting
      for (int ph = 0; ph < 6; ph++) begin
         set_mode(ph[0] ? MODE_HRN : MODE_FCFS);
         idle_on = (ph != 3);
         for (int i = 0; i < 300; i++) begin
            send_item(rand_item(ph[0]));
            if (i == 150) while (grants_due.size() != 0) @(posedge clock);
         end
      end
      idle_on = 1;
      set_mode(MODE_FCFS);

      while (grants_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("sent %0d items (%0d under hrn), %0d grants checked", n_sent, n_hrn,
               n_grants);
      if (errors == 0 && grants_due.size() == 0)
         $display("hrn_fcfs_job_scheduler_tb: PASS");
      else
         $display("hrn_fcfs_job_scheduler_tb: FAIL");
      $finish;
   end

endmodule
